// File: rtl/mest_pkg.sv
// Shared types, constants and helpers for the expected-sample table.
package mest_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int ACC_W     = 36;
  localparam int FRAC_BITS = 13;
  localparam int OUT_W     = 18;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 4;
  localparam int IDX_W     = 8;
  localparam int ENTRIES   = 4;
  localparam int MAX_TAPS  = 4;
  localparam int SHIFT_W   = ACC_W - FRAC_BITS;

  localparam logic [CFG_W-1:0] SYM_LO_RST  = 64'h2000_E000_0000_2000;
  localparam logic [CFG_W-1:0] SYM_HI_RST  = 64'h0;
  localparam logic [CFG_W-1:0] TAPS_LO_RST = 64'h0000_0000_0000_2000;
  localparam logic [CFG_W-1:0] TAPS_HI_RST = 64'h0;

  localparam logic signed [SHIFT_W-1:0] OUT_MAX = SHIFT_W'(131071);
  localparam logic signed [SHIFT_W-1:0] OUT_MIN = -SHIFT_W'(131072);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYM_LO  = 4'd0,
    REG_SYM_HI  = 4'd1,
    REG_TAPS_LO = 4'd2,
    REG_TAPS_HI = 4'd3
  } cfg_reg_e;

  // Complex Q2.13 value, real in the low half.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] im;
    logic signed [SAMPLE_W-1:0] re;
  } cplx_t;

  // Partial products of one tap.
  typedef struct packed {
    logic signed [PROD_W-1:0] rr;
    logic signed [PROD_W-1:0] ii;
    logic signed [PROD_W-1:0] ri;
    logic signed [PROD_W-1:0] ir;
  } prod_t;

  // Floor shift by the fraction width, then clamp to the output range.
  function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [SHIFT_W-1:0] sh;
    logic signed [OUT_W-1:0]   res;
    sh = acc[ACC_W-1:FRAC_BITS];
    if (sh > OUT_MAX) begin
      res = OUT_MAX[OUT_W-1:0];
    end else if (sh < OUT_MIN) begin
      res = OUT_MIN[OUT_W-1:0];
    end else begin
      res = sh[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/mest_tap_mult.sv
// One tap lane: modulation entry lookup and registered complex partial products.
module mest_tap_mult #(
  parameter int SYM_BITS     = 2,
  parameter int SYMBOL_COUNT = 4
) (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic [SYM_BITS-1:0]                        sym_i,
  input  mest_pkg::cplx_t [mest_pkg::ENTRIES-1:0]    sym_tab_i,
  input  mest_pkg::cplx_t                            coef_i,
  output mest_pkg::prod_t                            prod_o
);

  logic [SYM_BITS+1:0] sym_ext;
  logic [1:0]          ent;
  logic                hit;
  mest_pkg::cplx_t     a;
  mest_pkg::prod_t     prod_d, prod_q;

  assign sym_ext = {2'b00, sym_i};
  assign ent     = sym_ext[1:0];
  assign hit     = (int'(sym_i) < SYMBOL_COUNT) && (int'(sym_i) < mest_pkg::ENTRIES);

  always_comb begin
    // Symbols with no table entry contribute nothing.
    a = hit ? sym_tab_i[ent] : '0;
    prod_d.rr = a.re * coef_i.re;
    prod_d.ii = a.im * coef_i.im;
    prod_d.ri = a.re * coef_i.im;
    prod_d.ir = a.im * coef_i.re;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/mlse_expected_sample_table_top.sv
// Top level of the expected-sample table for a sequence equalizer.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one packed symbol
//   history per item; the output channel (out_valid_o / out_ready_i) returns
//   the expected complex sample for it, Q4.13 saturated to 18 bits. Four 64-bit
//   registers (symbol table, taps; low/high each) must be written by the user
//   via cfg_we_i/cfg_idx_i/cfg_data_i while no item is in flight; not enforced.
// Timing:
//   Three register stages: input, partial products (one multiplier per product
//   per tap), and sum with shift and clamp. An accepted item moves through
//   them to out_valid_o; throughput is one item per cycle unless stalled.
// Reset:
//   Registers return to their defaults (entries 1+0j and -1+1j, tap 0 = 1),
//   and the pipeline empties.
// Stall:
//   When out_ready_i is low, stages fill in turn; in_ready_o drops only once
//   every stage holds an item. No item is lost or repeated.
module mlse_expected_sample_table_top #(
  parameter int TAPS         = 4,
  parameter int SYMBOL_COUNT = 4,
  parameter int SYM_BITS     = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mest_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mest_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mest_pkg::IDX_W-1:0]            history_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mest_pkg::OUT_W-1:0]     expected_real_o,
  output logic signed [mest_pkg::OUT_W-1:0]     expected_imag_o
);

  localparam int LANES = (TAPS < mest_pkg::MAX_TAPS) ? TAPS : mest_pkg::MAX_TAPS;
  localparam int EXT_W = mest_pkg::IDX_W + LANES * SYM_BITS;

  logic [mest_pkg::CFG_W-1:0] sym_lo_q, sym_hi_q, taps_lo_q, taps_hi_q;

  logic s1_v_q, s2_v_q, out_v_q;
  logic en1, en2, en3;

  logic [mest_pkg::IDX_W-1:0] hist_q;
  logic [EXT_W-1:0]           hist_ext;

  mest_pkg::cplx_t [mest_pkg::ENTRIES-1:0]  sym_tab;
  mest_pkg::cplx_t [mest_pkg::MAX_TAPS-1:0] coef;
  mest_pkg::prod_t [LANES-1:0]              prod;

  logic signed [mest_pkg::ACC_W-1:0] acc_re, acc_im;
  logic signed [mest_pkg::OUT_W-1:0] res_re_q, res_im_q;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q  <= mest_pkg::SYM_LO_RST;
      sym_hi_q  <= mest_pkg::SYM_HI_RST;
      taps_lo_q <= mest_pkg::TAPS_LO_RST;
      taps_hi_q <= mest_pkg::TAPS_HI_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mest_pkg::REG_SYM_LO:  sym_lo_q  <= cfg_data_i;
        mest_pkg::REG_SYM_HI:  sym_hi_q  <= cfg_data_i;
        mest_pkg::REG_TAPS_LO: taps_lo_q <= cfg_data_i;
        mest_pkg::REG_TAPS_HI: taps_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sym_tab[0] = sym_lo_q[31:0];
  assign sym_tab[1] = sym_lo_q[63:32];
  assign sym_tab[2] = sym_hi_q[31:0];
  assign sym_tab[3] = sym_hi_q[63:32];
  assign coef[0]    = taps_lo_q[31:0];
  assign coef[1]    = taps_lo_q[63:32];
  assign coef[2]    = taps_hi_q[31:0];
  assign coef[3]    = taps_hi_q[63:32];

  // A stage advances when it is empty or the next one moves.
  assign en3        = !out_v_q || out_ready_i;
  assign en2        = !s2_v_q || en3;
  assign en1        = !s1_v_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q  <= in_valid_i;
      if (en2) s2_v_q  <= s1_v_q;
      if (en3) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      hist_q <= history_index_i;
    end
  end

  // Taps past the index width see symbol zero.
  assign hist_ext = {{(LANES * SYM_BITS){1'b0}}, hist_q};

  for (genvar t = 0; t < LANES; t++) begin : g_lane
    mest_tap_mult #(
      .SYM_BITS     (SYM_BITS),
      .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en2),
      .sym_i     (hist_ext[t*SYM_BITS +: SYM_BITS]),
      .sym_tab_i (sym_tab),
      .coef_i    (coef[t]),
      .prod_o    (prod[t])
    );
  end

  always_comb begin
    acc_re = '0;
    acc_im = '0;
    for (int t = 0; t < LANES; t++) begin
      acc_re = acc_re + mest_pkg::ACC_W'(prod[t].rr) - mest_pkg::ACC_W'(prod[t].ii);
      acc_im = acc_im + mest_pkg::ACC_W'(prod[t].ri) + mest_pkg::ACC_W'(prod[t].ir);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      res_re_q <= mest_pkg::scale_sat(acc_re);
      res_im_q <= mest_pkg::scale_sat(acc_im);
    end
  end

  assign out_valid_o     = out_v_q;
  assign expected_real_o = res_re_q;
  assign expected_imag_o = res_im_q;

  // An accepted item lands in the first stage.
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_v_q)
    else $error("accepted item not captured");

  // An empty pipeline always takes an item.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q && !s2_v_q && !out_v_q |-> in_ready_o)
    else $error("empty pipeline refuses input");

  // A product stage item blocked downstream is held.
  a_hold_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !en3 |=> s2_v_q)
    else $error("stalled item dropped");

  // A moving first stage item reaches the product stage.
  a_move_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && en2 |=> s2_v_q)
    else $error("item lost between stages");

endmodule

// File: sim/mest_sample_checker.sv
// Checker for the expected-sample table: snoops register writes, predicts and compares samples.
`timescale 1ns / 1ps

module mest_sample_checker #(
  parameter int TAPS         = 4,
  parameter int SYMBOL_COUNT = 4,
  parameter int SYM_BITS     = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mest_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mest_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [mest_pkg::IDX_W-1:0]            history_index_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic signed [mest_pkg::OUT_W-1:0]     expected_real_i,
  input  logic signed [mest_pkg::OUT_W-1:0]     expected_imag_i,
  output int                                    pending_o,
  output int                                    checked_o,
  output int                                    clamped_o,
  output int                                    mismatches_o
);

  localparam longint SAT_HI    = 131071;
  localparam longint SAT_LO    = -131072;
  localparam int     MAX_SHOWN = 50;

  typedef struct packed {
    logic signed [mest_pkg::OUT_W-1:0] re;
    logic signed [mest_pkg::OUT_W-1:0] im;
  } sample_t;

  logic [mest_pkg::CFG_W-1:0] sym_lo_q, sym_hi_q, taps_lo_q, taps_hi_q;
  sample_t                    expected_samples_q[$];
  sample_t                    want;

  // Entry k of a register pair: low word holds entries 0 and 1.
  function automatic mest_pkg::cplx_t pick_entry(input logic [mest_pkg::CFG_W-1:0] lo_word,
                                                 input logic [mest_pkg::CFG_W-1:0] hi_word,
                                                 input int k);
    logic [mest_pkg::CFG_W-1:0] word;
    word = (k < 2) ? lo_word : hi_word;
    return mest_pkg::cplx_t'(word[(k % 2) * 32 +: 32]);
  endfunction

  // Floor by the fraction width, then clamp to 18 bits.
  function automatic logic signed [mest_pkg::OUT_W-1:0] floor_clamp(input longint acc);
    longint scaled;
    scaled = acc >>> mest_pkg::FRAC_BITS;
    if (scaled > SAT_HI) begin
      scaled = SAT_HI;
    end else if (scaled < SAT_LO) begin
      scaled = SAT_LO;
    end
    return scaled[mest_pkg::OUT_W-1:0];
  endfunction

  function automatic sample_t expected_sample(input logic [mest_pkg::IDX_W-1:0] idx);
    sample_t         res;
    mest_pkg::cplx_t sym_val, coef;
    longint          sr, si, cr, ci, acc_re, acc_im;
    int              sym;
    acc_re = 0;
    acc_im = 0;
    for (int t = 0; t < TAPS; t++) begin
      sym = int'((32'(idx) >> (t * SYM_BITS)) & ((32'd1 << SYM_BITS) - 1));
      // Taps or symbols without a stored entry add nothing.
      if (t < mest_pkg::MAX_TAPS && sym < SYMBOL_COUNT && sym < mest_pkg::ENTRIES) begin
        sym_val = pick_entry(sym_lo_q, sym_hi_q, sym);
        coef    = pick_entry(taps_lo_q, taps_hi_q, t);
        sr = longint'($signed(sym_val.re));
        si = longint'($signed(sym_val.im));
        cr = longint'($signed(coef.re));
        ci = longint'($signed(coef.im));
        acc_re += sr * cr - si * ci;
        acc_im += sr * ci + si * cr;
      end
    end
    res.re = floor_clamp(acc_re);
    res.im = floor_clamp(acc_im);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q  <= mest_pkg::SYM_LO_RST;
      sym_hi_q  <= mest_pkg::SYM_HI_RST;
      taps_lo_q <= mest_pkg::TAPS_LO_RST;
      taps_hi_q <= mest_pkg::TAPS_HI_RST;
      expected_samples_q.delete();
      pending_o    <= 0;
      checked_o    <= 0;
      clamped_o    <= 0;
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mest_pkg::REG_SYM_LO:  sym_lo_q  <= cfg_data_i;
          mest_pkg::REG_SYM_HI:  sym_hi_q  <= cfg_data_i;
          mest_pkg::REG_TAPS_LO: taps_lo_q <= cfg_data_i;
          mest_pkg::REG_TAPS_HI: taps_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Retire first: a sample leaving now belongs to an older item.
      if (out_valid_i && out_ready_i) begin
        if (expected_samples_q.size() == 0) begin
          mismatches_o = mismatches_o + 1;
          if (mismatches_o <= MAX_SHOWN) begin
            $display("%0t: sample with no item pending: real %0d imag %0d",
                     $time, expected_real_i, expected_imag_i);
          end
        end else begin
          want = expected_samples_q.pop_front();
          checked_o <= checked_o + 1;
          if (want.re == SAT_HI[mest_pkg::OUT_W-1:0] || want.re == SAT_LO[mest_pkg::OUT_W-1:0] ||
              want.im == SAT_HI[mest_pkg::OUT_W-1:0] || want.im == SAT_LO[mest_pkg::OUT_W-1:0])
          begin
            clamped_o <= clamped_o + 1;
          end
          if (want.re !== expected_real_i) begin
            mismatches_o = mismatches_o + 1;
            if (mismatches_o <= MAX_SHOWN) begin
              $display("%0t: expected_real expected %0d, got %0d",
                       $time, $signed(want.re), expected_real_i);
            end
          end
          if (want.im !== expected_imag_i) begin
            mismatches_o = mismatches_o + 1;
            if (mismatches_o <= MAX_SHOWN) begin
              $display("%0t: expected_imag expected %0d, got %0d",
                       $time, $signed(want.im), expected_imag_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_samples_q.push_back(expected_sample(history_index_i));
      end
      pending_o <= expected_samples_q.size();
    end
  end

endmodule

// File: sim/tb_mlse_expected_sample_table_top.sv
// Testbench top for the expected-sample table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_mlse_expected_sample_table_top;

  localparam int TAPS             = 4;
  localparam int SYMBOL_COUNT     = 4;
  localparam int SYM_BITS         = 2;
  localparam int REG_COUNT        = 4;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RAND_PER_SETTING = 102;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we;
  logic [mest_pkg::CFG_IDX_W-1:0]     cfg_idx;
  logic [mest_pkg::CFG_W-1:0]         cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic [mest_pkg::IDX_W-1:0]         history_index;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [mest_pkg::OUT_W-1:0]  expected_real;
  logic signed [mest_pkg::OUT_W-1:0]  expected_imag;

  int pending, checked, clamped, mismatches;
  int tx_idle_pct, rx_idle_pct;
  int items_sent, settings_used, stall_cycles;

  mlse_expected_sample_table_top #(
    .TAPS         (TAPS),
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .SYM_BITS     (SYM_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .history_index_i (history_index),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .expected_real_o (expected_real),
    .expected_imag_o (expected_imag)
  );

  mest_sample_checker #(
    .TAPS         (TAPS),
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .SYM_BITS     (SYM_BITS)
  ) sample_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .history_index_i (history_index),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .expected_real_i (expected_real),
    .expected_imag_i (expected_imag),
    .pending_o       (pending),
    .checked_o       (checked),
    .clamped_o       (clamped),
    .mismatches_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a handshake", stall_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [mest_pkg::IDX_W-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    history_index <= idx;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender until every pending sample has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [mest_pkg::CFG_W-1:0] sym_lo,
                              input logic [mest_pkg::CFG_W-1:0] sym_hi,
                              input logic [mest_pkg::CFG_W-1:0] taps_lo,
                              input logic [mest_pkg::CFG_W-1:0] taps_hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= mest_pkg::REG_SYM_LO;
    cfg_data <= sym_lo;
    @(negedge clk_i);
    cfg_idx  <= mest_pkg::REG_SYM_HI;
    cfg_data <= sym_hi;
    @(negedge clk_i);
    cfg_idx  <= mest_pkg::REG_TAPS_LO;
    cfg_data <= taps_lo;
    @(negedge clk_i);
    cfg_idx  <= mest_pkg::REG_TAPS_HI;
    cfg_data <= taps_hi;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    settings_used++;
  endtask

  // A write to an unmapped index must leave every register alone.
  task automatic write_spare_reg();
    cfg_we   <= 1'b1;
    cfg_idx  <= mest_pkg::CFG_IDX_W'($urandom_range(2 ** mest_pkg::CFG_IDX_W - 1, REG_COUNT));
    cfg_data <= {$urandom, $urandom};
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [mest_pkg::SAMPLE_W-1:0] rand_q13();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h2000;
      4: return 16'hE000;
      default: return mest_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [mest_pkg::CFG_W-1:0] rand_reg();
    if ($urandom_range(3) == 0) begin
      return {$urandom, $urandom};
    end
    return {rand_q13(), rand_q13(), rand_q13(), rand_q13()};
  endfunction

  function automatic logic [mest_pkg::IDX_W-1:0] rand_index();
    logic [SYM_BITS-1:0] sym;
    if ($urandom_range(4) == 0) begin
      sym = SYM_BITS'($urandom_range(2 ** SYM_BITS - 1));
      return {TAPS{sym}};
    end
    return mest_pkg::IDX_W'($urandom_range(2 ** mest_pkg::IDX_W - 1));
  endfunction

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = mest_pkg::REG_SYM_LO;
    cfg_data      = '0;
    in_valid      = 1'b0;
    history_index = '0;
    tx_idle_pct   = 7;
    rx_idle_pct   = 87;
    items_sent    = 0;
    settings_used = 1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Defaults after reset.
    send_item(8'h00); send_item(8'hFF); send_item(8'h55);
    send_item(8'hAA); send_item(8'hE4); send_item(8'h1B);
    drain();
    program_regs('0, '0, '0, '0);
    send_item(8'hFF); send_item(8'h00);
    // Largest magnitudes: real sum far above the positive limit.
    drain();
    program_regs(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                 64'h7FFF_8000_7FFF_8000, 64'h7FFF_8000_7FFF_8000);
    send_item(8'h00); send_item(8'hFF);
    // Same symbols, conjugate-like taps: real sum far below the negative limit.
    drain();
    program_regs(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                 64'h8000_7FFF_8000_7FFF, 64'h8000_7FFF_8000_7FFF);
    send_item(8'h00); send_item(8'h93);
    // Tiny sums: floor rounds toward minus infinity.
    drain();
    program_regs('1, '1, '1, '1);
    send_item(8'hFF);
    drain();
    program_regs(64'h0000_FFFF_0000_FFFF, 64'h0000_FFFF_0000_FFFF,
                 64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001);
    send_item(8'h00);
    // Distinct entries so every tap and symbol position shows up.
    drain();
    program_regs(64'h0C00_E800_1000_2000, 64'hD000_F400_A000_5000,
                 64'h0800_1C00_0200_3000, 64'hF800_0A00_FC00_E400);
    send_item(8'h00); send_item(8'h01); send_item(8'h02); send_item(8'h03);
    send_item(8'h04); send_item(8'h10); send_item(8'h40); send_item(8'hE4);
    drain();
    write_spare_reg();
    send_item(8'hE4);

    for (int mix = 0; mix < 3; mix++) begin
      tx_idle_pct = (mix == 0) ? 7 : (mix == 1) ? 87 : 0;
      rx_idle_pct = (mix == 0) ? 87 : (mix == 1) ? 7 : 0;
      for (int s = 0; s < 4; s++) begin
        drain();
        if (s == 2) begin
          write_spare_reg();
        end
        program_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg());
        for (int n = 0; n < RAND_PER_SETTING; n++) begin
          send_item(rand_index());
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d samples for %0d history indices over %0d register settings,",
             checked, items_sent, settings_used);
    $display("%0d of them at a saturation limit, under three flow-control mixes.", clamped);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mest_pkg.sv
rtl/mest_tap_mult.sv
rtl/mlse_expected_sample_table_top.sv
sim/mest_sample_checker.sv
sim/tb_mlse_expected_sample_table_top.sv
